>>> hdl/level_dependent_lowpass_defines.svh
// ----------------------------------------------------------------------------
// level_dependent_lowpass_defines
// Assertion macros shared by the level-dependent low-pass RTL.
// ----------------------------------------------------------------------------
`ifndef LEVEL_DEPENDENT_LOWPASS_DEFINES_SVH
`define LEVEL_DEPENDENT_LOWPASS_DEFINES_SVH

// same-cycle implication
`define LDL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LDL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/ldl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldl_pkg
// Types, constants and small tables for the level-dependent low-pass.
// ----------------------------------------------------------------------------
package ldl_pkg;

  localparam int CHANNELS_DEF      = 2;
  localparam int UPDATE_PERIOD_DEF = 16;
  localparam int CNT_W             = 8;   // holds UPDATE_PERIOD-1 up to 255
  localparam int APB_AW            = 5;

  // register map (word index)
  localparam logic [2:0] REG_LEVEL_DECAY  = 3'd0;
  localparam logic [2:0] REG_OMEGA        = 3'd1;
  localparam logic [2:0] REG_INIT_COEF    = 3'd2;
  localparam logic [2:0] REG_BANDWIDTH    = 3'd3;
  localparam logic [2:0] REG_TAPE         = 3'd4;
  localparam logic [2:0] REG_DRIVE        = 3'd5;
  localparam logic [2:0] REG_SPEED        = 3'd6;

  localparam logic [23:0] RST_LEVEL_DECAY = 24'd16771392;
  localparam logic [23:0] RST_OMEGA       = 24'd562210;
  localparam logic [23:0] RST_INIT_COEF   = 24'd14712000;
  localparam logic [15:0] RST_BANDWIDTH   = 16'd65535;
  localparam logic [1:0]  RST_SPEED       = 2'd1;

  localparam logic [31:0] ENV_FLOOR  = 32'd4;
  localparam logic [31:0] W_BASE     = 32'd29491;
  localparam logic [31:0] W_SPAN     = 32'd36045;
  localparam logic [31:0] K_TAPE     = 32'd20972;
  localparam logic [31:0] K_DRIVE    = 32'd11796;
  localparam logic [31:0] K_SMOOTH   = 32'd11796;
  localparam logic [31:0] K_KEEP     = 32'd53740;  // 65536 - K_SMOOTH
  localparam logic [17:0] LOSS_MIN   = 18'd29491;
  localparam logic [31:0] INV_LN2    = 32'd24204406;
  localparam logic [31:0] LN2_Q30    = 32'd744261118;
  localparam logic [30:0] ONE_Q30    = 31'h4000_0000;
  localparam logic [31:0] X_LIMIT    = 32'd285212672;  // 17.0 in Q.24
  localparam int          ROOT_STEPS = 17;

  typedef struct packed {
    logic [31:0]      env;
    logic [31:0]      fmem;
    logic [23:0]      coef;
    logic [CNT_W-1:0] cnt;
  } entry_t;

  function automatic logic [14:0] base_hz(input logic [1:0] speed);
    case (speed)
      2'd0:    base_hz = 15'd9500;
      2'd1:    base_hz = 15'd13200;
      default: base_hz = 15'd17500;
    endcase
  endfunction

  // floor(2^32 / k), k = 2..10
  function automatic logic [31:0] recip(input logic [3:0] k);
    case (k)
      4'd2:    recip = 32'd2147483648;
      4'd3:    recip = 32'd1431655765;
      4'd4:    recip = 32'd1073741824;
      4'd5:    recip = 32'd858993459;
      4'd6:    recip = 32'd715827882;
      4'd7:    recip = 32'd613566756;
      4'd8:    recip = 32'd536870912;
      4'd9:    recip = 32'd477218588;
      4'd10:   recip = 32'd429496729;
      default: recip = 32'hFFFF_FFFF;
    endcase
  endfunction

endpackage

>>> hdl/ldl_state_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldl_state_ram
// Per-channel state memory, one write port, one registered read port.
// ----------------------------------------------------------------------------
module ldl_state_ram import ldl_pkg::*; #(
  parameter int CHANNELS = CHANNELS_DEF,
  parameter int AW       = 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  entry_t        wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output entry_t        rdata
);

  entry_t mem [CHANNELS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/ldl_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldl_sqrt
// Bit-serial integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module ldl_sqrt import ldl_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [32:0] value,
  output logic [16:0] root,
  output logic        done
);

  logic [33:0] op;
  logic [18:0] rem;
  logic [4:0]  steps;
  logic        busy;
  logic [20:0] rem_sh;
  logic [20:0] trial;

  assign rem_sh = {rem, op[33:32]};
  assign trial  = {2'b00, root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        op    <= {1'b0, value};
        rem   <= '0;
        root  <= '0;
        steps <= 5'(ROOT_STEPS);
        busy  <= 1'b1;
      end else if (busy) begin
        if (rem_sh >= trial) begin
          rem  <= 19'(rem_sh - trial);
          root <= {root[15:0], 1'b1};
        end else begin
          rem  <= rem_sh[18:0];
          root <= {root[15:0], 1'b0};
        end
        op    <= {op[31:0], 2'b00};
        steps <= steps - 5'd1;
        if (steps == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> hdl/ldl_exp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldl_exp
// Sequenced 1 - exp(-x): x in Q.24, result Q0.24. exp is taken as
// 2^-(n+f) with a 10-term Horner series for 2^-f on one shared multiplier.
// ----------------------------------------------------------------------------
module ldl_exp import ldl_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] x,
  output logic [23:0] target,
  output logic        done
);

  localparam logic [3:0] X_IDLE = 4'd0;
  localparam logic [3:0] X_Y    = 4'd1;
  localparam logic [3:0] X_T    = 4'd2;
  localparam logic [3:0] X_H    = 4'd3;
  localparam logic [3:0] X_LD   = 4'd4;
  localparam logic [3:0] X_A    = 4'd5;
  localparam logic [3:0] X_B    = 4'd6;
  localparam logic [3:0] X_C    = 4'd7;
  localparam logic [3:0] X_FIN  = 4'd8;

  logic [3:0]  state;
  logic [31:0] xr;
  logic [63:0] prod;
  logic [31:0] mul_a, mul_b;
  logic [6:0]  n;
  logic [23:0] frac;
  logic [29:0] t;
  logic [30:0] h;
  logic [3:0]  k;
  logic [31:0] q;
  logic [63:0] y_sum;
  logic [35:0] est_k;
  logic [35:0] rem;
  logic [31:0] est;
  logic [31:0] quot;
  logic [5:0]  s;
  logic [47:0] hw;
  logic [47:0] e24;

  always_comb begin
    case (state)
      X_Y:     begin mul_a = xr;             mul_b = INV_LN2;   end
      X_H:     begin mul_a = {8'b0, frac};   mul_b = LN2_Q30;   end
      X_A:     begin mul_a = {2'b0, t};      mul_b = {1'b0, h}; end
      X_B:     begin mul_a = prod[61:30];    mul_b = recip(k);  end
      default: begin mul_a = '0;             mul_b = '0;        end
    endcase
  end

  assign y_sum = prod + 64'h80_0000;
  assign est   = prod[63:32];
  assign est_k = 36'(est) * 36'(k);
  assign rem   = 36'(q) - est_k;

  // reciprocal estimate is at most one low
  always_comb begin
    if (k == 4'd1) begin
      quot = q;
    end else if (rem >= 36'(k)) begin
      quot = est + 32'd1;
    end else begin
      quot = est;
    end
  end

  assign s   = ((n > 7'd40) ? 6'd40 : n[5:0]) + 6'd6;
  assign hw  = {17'b0, h} + (48'd1 << (s - 6'd1));
  assign e24 = hw >> s;

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= X_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        X_IDLE: begin
          if (start) begin
            xr <= x;
            if (x >= X_LIMIT) begin
              target <= 24'hFF_FFFF;
              done   <= 1'b1;
            end else begin
              state <= X_Y;
            end
          end
        end
        X_Y: state <= X_T;
        X_T: begin
          n     <= y_sum[54:48];
          frac  <= y_sum[47:24];
          state <= X_H;
        end
        X_H: state <= X_LD;
        // fraction times ln2 has landed: load series start
        X_LD: begin
          t     <= prod[53:24];
          h     <= ONE_Q30;
          k     <= 4'd10;
          state <= X_A;
        end
        X_A: state <= X_B;
        X_B: begin
          q     <= prod[61:30];
          state <= X_C;
        end
        X_C: begin
          h <= ONE_Q30 - quot[30:0];
          if (k == 4'd1) begin
            state <= X_FIN;
          end else begin
            k     <= k - 4'd1;
            state <= X_A;
          end
        end
        X_FIN: begin
          if (e24 >= 48'h100_0000) begin
            target <= '0;
          end else if (e24 == 48'd0) begin
            target <= 24'hFF_FFFF;
          end else begin
            target <= 24'(48'h100_0000 - e24);
          end
          done  <= 1'b1;
          state <= X_IDLE;
        end
        default: state <= X_IDLE;
      endcase
    end
  end

endmodule

>>> hdl/level_dependent_lowpass.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// level_dependent_lowpass
// Per-channel envelope-controlled one-pole low-pass, state kept in a RAM.
// ----------------------------------------------------------------------------
// channel  | dir | signals
// s_*      | in  | tvalid/tready, tdata = sample_in, tuser = channel
// m_*      | out | tvalid/tready, tdata = sample_out
// APB      | i/o | psel/penable/pwrite/paddr/pwdata, prdata, pready
//
// One request at a time: the next request is taken once the result has been
// loaded into the output register, after a root wait of 17 root steps. Every
// UPDATE_PERIOD-th request of a channel also recomputes the coefficient through
// the exp unit, which skips its series when exp(-x) underflows. Top and exp unit
// each use one 32x32 multiplier. Synchronous reset; per-entry valid bits supply
// reset values. A result held in the output register stalls the next request.
// ----------------------------------------------------------------------------
`include "level_dependent_lowpass_defines.svh"

module level_dependent_lowpass import ldl_pkg::*; #(
  parameter int CHANNELS      = CHANNELS_DEF,
  parameter int UPDATE_PERIOD = UPDATE_PERIOD_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [23:0]       s_tdata,   // [23:0] sample_in
  input  logic              s_tuser,   // [0] channel
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [23:0]       m_tdata,   // [23:0] sample_out
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_RD   = 5'd1;
  localparam logic [4:0] ST_SQ   = 5'd2;
  localparam logic [4:0] ST_E1   = 5'd3;
  localparam logic [4:0] ST_E2   = 5'd4;
  localparam logic [4:0] ST_ROOT = 5'd5;
  localparam logic [4:0] ST_W1   = 5'd6;
  localparam logic [4:0] ST_W2   = 5'd7;
  localparam logic [4:0] ST_W3   = 5'd8;
  localparam logic [4:0] ST_W4   = 5'd9;
  localparam logic [4:0] ST_W5   = 5'd10;
  localparam logic [4:0] ST_W6   = 5'd11;
  localparam logic [4:0] ST_W7   = 5'd12;
  localparam logic [4:0] ST_W8   = 5'd13;
  localparam logic [4:0] ST_W9   = 5'd14;
  localparam logic [4:0] ST_W10  = 5'd15;
  localparam logic [4:0] ST_EXP  = 5'd16;
  localparam logic [4:0] ST_C1   = 5'd17;
  localparam logic [4:0] ST_C2   = 5'd18;
  localparam logic [4:0] ST_F1   = 5'd19;
  localparam logic [4:0] ST_F2   = 5'd20;
  localparam logic [4:0] ST_F3   = 5'd21;
  localparam logic [4:0] ST_OUT  = 5'd22;

  // configuration
  logic [23:0] level_decay, omega_per_hz, initial_coefficient;
  logic [15:0] bandwidth, tape_amount, drive_amount;
  logic [1:0]  tape_speed;
  logic        cfg_we;
  logic [2:0]  cfg_idx;

  // sequencer and working registers
  logic [4:0]          state;
  logic [AW-1:0]       ch;
  logic [AW-1:0]       ch_in;
  logic [23:0]         raw;
  logic [31:0]         env, fmem, sq;
  logic [23:0]         coef;
  logic [CNT_W-1:0]    cnt;
  logic [63:0]         acc, prod;
  logic [31:0]         mul_a, mul_b;
  logic [16:0]         level, width_q, loss;
  logic [15:0]         mix;
  logic [31:0]         cutoff;
  logic [23:0]         result;
  logic [CHANNELS-1:0] valid, coef_valid;

  logic [23:0] mag;
  logic [63:0] sum_r23, sum_r15, prod_r15, prod_r23;
  logic [31:0] env_new, unew;
  logic [32:0] out_round;
  logic [17:0] loss_raw;
  logic [31:0] u_biased, ux;

  entry_t rd_entry, wr_entry;
  logic   ram_we, ram_re;

  logic        root_start, root_done;
  logic [16:0] root;
  logic        exp_start, exp_done;
  logic [23:0] target;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:2];
  assign cfg_we  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      level_decay         <= RST_LEVEL_DECAY;
      omega_per_hz        <= RST_OMEGA;
      initial_coefficient <= RST_INIT_COEF;
      bandwidth           <= RST_BANDWIDTH;
      tape_amount         <= '0;
      drive_amount        <= '0;
      tape_speed          <= RST_SPEED;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_LEVEL_DECAY: level_decay         <= pwdata[23:0];
        REG_OMEGA:       omega_per_hz        <= pwdata[23:0];
        REG_INIT_COEF:   initial_coefficient <= pwdata[23:0];
        REG_BANDWIDTH:   bandwidth           <= pwdata[15:0];
        REG_TAPE:        tape_amount         <= pwdata[15:0];
        REG_DRIVE:       drive_amount        <= pwdata[15:0];
        REG_SPEED:       tape_speed          <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_LEVEL_DECAY: prdata = {8'b0, level_decay};
      REG_OMEGA:       prdata = {8'b0, omega_per_hz};
      REG_INIT_COEF:   prdata = {8'b0, initial_coefficient};
      REG_BANDWIDTH:   prdata = {16'b0, bandwidth};
      REG_TAPE:        prdata = {16'b0, tape_amount};
      REG_DRIVE:       prdata = {16'b0, drive_amount};
      REG_SPEED:       prdata = {30'b0, tape_speed};
      default:         prdata = '0;
    endcase
  end

  // channel clamp
  assign ch_in = (32'(s_tuser) >= CHANNELS) ? AW'(CHANNELS - 1) : AW'(s_tuser);

  assign s_tready = (state == ST_IDLE);
  assign ram_re   = s_tvalid && s_tready;

  assign mag      = raw[23] ? 24'(25'h100_0000 - {1'b0, raw}) : raw;
  assign sum_r23  = acc + prod + 64'h80_0000;
  assign sum_r15  = acc + prod + 64'h8000;
  assign prod_r15 = prod + 64'h8000;
  assign prod_r23 = prod + 64'h80_0000;
  assign env_new  = sum_r23[55:24];
  assign unew     = sum_r23[55:24];
  assign out_round = {1'b0, unew} + 33'd128;
  assign loss_raw  = 18'h1_0000 - {1'b0, prod_r15[32:16]};
  assign u_biased  = fmem ^ 32'h8000_0000;
  assign ux        = {raw ^ 24'h80_0000, 8'b0};

  assign root_start = (state == ST_E2);
  assign exp_start  = (state == ST_W10);

  always_comb begin
    case (state)
      ST_RD:   begin mul_a = {8'b0, mag};              mul_b = {8'b0, mag};             end
      ST_SQ:   begin mul_a = {8'b0, level_decay};      mul_b = env;                     end
      ST_E1:   begin mul_a = 32'h100_0000 - {8'b0, level_decay}; mul_b = sq;            end
      ST_W1:   begin mul_a = {16'b0, bandwidth};       mul_b = W_SPAN;                  end
      ST_W2:   begin mul_a = {16'b0, tape_amount};     mul_b = K_TAPE;                  end
      ST_W3:   begin mul_a = {16'b0, drive_amount};    mul_b = K_DRIVE;                 end
      ST_W5:   begin mul_a = {15'b0, level};           mul_b = {16'b0, mix};            end
      ST_W6:   begin mul_a = {17'b0, base_hz(tape_speed)}; mul_b = {15'b0, width_q};    end
      ST_W7:   begin mul_a = prod[31:0];               mul_b = {15'b0, loss};           end
      ST_W9:   begin mul_a = {8'b0, omega_per_hz};     mul_b = cutoff;                  end
      ST_EXP:  begin mul_a = {8'b0, coef};             mul_b = K_KEEP;                  end
      ST_C1:   begin mul_a = {8'b0, target};           mul_b = K_SMOOTH;                end
      ST_F1:   begin mul_a = u_biased;                 mul_b = 32'h100_0000 - {8'b0, coef}; end
      ST_F2:   begin mul_a = ux;                       mul_b = {8'b0, coef};            end
      default: begin mul_a = '0;                       mul_b = '0;                      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  assign wr_entry = '{env: env, fmem: unew ^ 32'h8000_0000, coef: coef, cnt: cnt};
  assign ram_we   = (state == ST_F3);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      valid      <= '0;
      coef_valid <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      // ST_OUT reloads the output register itself
      if (m_tvalid && m_tready && state != ST_OUT) begin
        m_tvalid <= 1'b0;
      end
      if (cfg_we && cfg_idx == REG_INIT_COEF) begin
        coef_valid <= '0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            ch    <= ch_in;
            raw   <= s_tdata;
            state <= ST_RD;
          end
        end
        ST_RD: begin
          env   <= valid[ch] ? rd_entry.env : '0;
          fmem  <= valid[ch] ? rd_entry.fmem : '0;
          cnt   <= valid[ch] ? rd_entry.cnt : '0;
          coef  <= coef_valid[ch] ? rd_entry.coef : initial_coefficient;
          state <= ST_SQ;
        end
        ST_SQ: begin
          sq    <= (prod[63:46] != '0) ? 32'hFFFF_FFFF : prod[45:14];
          state <= ST_E1;
        end
        ST_E1: begin
          acc   <= prod;
          state <= ST_E2;
        end
        ST_E2: begin
          env   <= env_new;
          state <= ST_ROOT;
        end
        ST_ROOT: begin
          if (root_done) begin
            level <= (root[16] || root[15]) ? 17'h1_0000 : {root[15:0], 1'b0};
            if (cnt == '0) begin
              state <= ST_W1;
            end else begin
              cnt   <= cnt - CNT_W'(1);
              state <= ST_F1;
            end
          end
        end
        ST_W1: state <= ST_W2;
        ST_W2: begin
          width_q <= 17'(W_BASE) + prod_r15[32:16];
          state   <= ST_W3;
        end
        ST_W3: begin
          acc   <= prod;
          state <= ST_W4;
        end
        ST_W4: begin
          mix   <= sum_r15[31:16];
          state <= ST_W5;
        end
        ST_W5: state <= ST_W6;
        ST_W6: begin
          loss  <= (loss_raw < LOSS_MIN) ? LOSS_MIN[16:0] : loss_raw[16:0];
          state <= ST_W7;
        end
        ST_W7: state <= ST_W8;
        ST_W8: begin
          cutoff <= prod_r15[47:16];
          state  <= ST_W9;
        end
        ST_W9:  state <= ST_W10;
        ST_W10: state <= ST_EXP;
        ST_EXP: begin
          if (exp_done) begin
            state <= ST_C1;
          end
        end
        ST_C1: begin
          acc   <= prod;
          state <= ST_C2;
        end
        ST_C2: begin
          coef  <= sum_r15[39:16];
          cnt   <= CNT_W'(UPDATE_PERIOD - 1);
          state <= ST_F1;
        end
        ST_F1: state <= ST_F2;
        ST_F2: begin
          acc   <= prod;
          state <= ST_F3;
        end
        ST_F3: begin
          valid[ch]      <= 1'b1;
          coef_valid[ch] <= 1'b1;
          result <= (out_round[32:8] > 25'hFF_FFFF) ? 24'h7F_FFFF
                                                    : out_round[31:8] ^ 24'h80_0000;
          state  <= ST_OUT;
        end
        ST_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= result;
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  ldl_state_ram #(
    .CHANNELS (CHANNELS),
    .AW       (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ch),
    .wdata (wr_entry),
    .re    (ram_re),
    .raddr (ch_in),
    .rdata (rd_entry)
  );

  ldl_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (root_start),
    .value ({1'b0, env_new} + {1'b0, ENV_FLOOR}),
    .root  (root),
    .done  (root_done)
  );

  ldl_exp u_exp (
    .clk    (clk),
    .rst    (rst),
    .start  (exp_start),
    .x      (prod_r23[55:24]),
    .target (target),
    .done   (exp_done)
  );

  `LDL_ASSERT_NEXT(a_accept_reads, s_tvalid && s_tready, state == ST_RD, "accept must start RAM read")
  `LDL_ASSERT_IMP(a_root_owner, root_done, state == ST_ROOT, "root finished outside wait state")
  `LDL_ASSERT_IMP(a_exp_owner, exp_done, state == ST_EXP, "exp finished outside wait state")
  `LDL_ASSERT_NEXT(a_out_load, state == ST_OUT && (!m_tvalid || m_tready), m_tvalid && s_tready, "result not loaded")

endmodule
